// ===== design/dlq_pkg.sv =====
// Package for the doubly linked queue manager.
// Holds node field widths, the default pool size and the opcode codes.
// No dependencies.
`default_nettype none

package dlq_pkg;

    // Width of a node field on the ports
    localparam int NODE_W = 8;
    // Width of the opcode field
    localparam int OP_W = 3;
    // Default number of nodes in the pool
    localparam int NODE_COUNT_DEF = 256;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 3'd0,
        OP_PUSH   = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_INSERT = 3'd4,
        OP_EMPTY  = 3'd5
    } opcode_t;

endpackage

`default_nettype wire

// ===== design/doubly_linked_queue_manager.sv =====
// One item at a time; the next input beat can be taken at the first edge that can
// take the previous result. A null link ends an item early.
// Reset: asynchronous, active low. A clearing pass then writes the null code into
// every link entry, with in_stall held high.
//
// Doubly linked queue manager top level; depends on dlq_pkg.
`default_nettype none

module doubly_linked_queue_manager #(
    parameter int NODE_COUNT = dlq_pkg::NODE_COUNT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [dlq_pkg::OP_W-1:0]   opcode,
    input  wire logic [dlq_pkg::NODE_W-1:0] target_node,
    input  wire logic [dlq_pkg::NODE_W-1:0] element_node,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [dlq_pkg::NODE_W-1:0]      result_node,
    output logic                            node_valid,
    output logic                            list_empty
);

    // Link width holds a node index or the null code NODE_COUNT
    localparam int LW   = $clog2(NODE_COUNT + 1);
    localparam int AW   = $clog2(NODE_COUNT);
    localparam int WIDE = LW + dlq_pkg::NODE_W;
    localparam logic [LW-1:0]   LINK_NULL = LW'(NODE_COUNT);
    localparam logic [WIDE-1:0] POOL_LIM  = WIDE'(NODE_COUNT);
    localparam logic [AW-1:0]   CLR_LAST  = AW'(NODE_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_WR,
        S_RD_TAIL,
        S_TAIL_DATA,
        S_RD_POS,
        S_POS_DATA,
        S_LINK_WR1,
        S_LINK_WR2,
        S_RD_HEAD,
        S_HEAD_DATA,
        S_RD_ELEM,
        S_ELEM_DATA,
        S_UNLINK_WR1,
        S_UNLINK_WR2,
        S_FINISH
    } state_t;

    state_t                     state_reg;
    dlq_pkg::opcode_t           op_reg;
    logic [dlq_pkg::NODE_W-1:0] tgt_reg;
    logic                       tpool_reg;
    logic [LW-1:0]              elm_reg;
    logic                       epool_reg;
    logic [LW-1:0]              pos_reg;
    logic                       pos_ok_reg;
    logic [LW-1:0]              nx_reg;
    logic [LW-1:0]              res_node_reg;
    logic                       res_valid_reg;
    logic                       res_empty_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic                       out_valid_reg;
    logic [dlq_pkg::NODE_W-1:0] result_node_reg;
    logic                       node_valid_reg;
    logic                       list_empty_reg;

    // Link memories
    logic [LW-1:0] prev_mem [NODE_COUNT];
    logic [LW-1:0] next_mem [NODE_COUNT];
    logic          prev_we;
    logic [AW-1:0] prev_addr;
    logic [LW-1:0] prev_wdata;
    logic [LW-1:0] prev_rd_reg;
    logic          next_we;
    logic [AW-1:0] next_addr;
    logic [LW-1:0] next_wdata;
    logic [LW-1:0] next_rd_reg;

    logic          in_beat;
    logic          in_tpool;
    logic          in_epool;
    logic [LW-1:0] link_nx;
    logic          head_is_root;

    assign in_beat  = in_valid && !in_stall;
    assign in_tpool = WIDE'(target_node) < POOL_LIM;
    assign in_epool = WIDE'(element_node) < POOL_LIM;
    // Successor of the new element after its own links were written
    assign link_nx  = (pos_reg == elm_reg) ? elm_reg : nx_reg;
    assign head_is_root = WIDE'(next_rd_reg) == WIDE'(tgt_reg);

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign result_node = result_node_reg;
    assign node_valid  = node_valid_reg;
    assign list_empty  = list_empty_reg;

    // Memory port control per sequencer step
    always_comb
    begin
        prev_we    = 1'b0;
        prev_addr  = '0;
        prev_wdata = LINK_NULL;
        next_we    = 1'b0;
        next_addr  = '0;
        next_wdata = LINK_NULL;
        case (state_reg)
            S_CLEAR:
            begin
                prev_we   = 1'b1;
                prev_addr = clr_cnt_reg;
                next_we   = 1'b1;
                next_addr = clr_cnt_reg;
            end
            S_INIT_WR:
            begin
                prev_we    = tpool_reg;
                prev_addr  = AW'(tgt_reg);
                prev_wdata = LW'(tgt_reg);
                next_we    = tpool_reg;
                next_addr  = AW'(tgt_reg);
                next_wdata = LW'(tgt_reg);
            end
            S_RD_TAIL:
            begin
                prev_addr = AW'(tgt_reg);
            end
            S_RD_POS:
            begin
                next_addr = pos_reg[AW-1:0];
            end
            S_LINK_WR1:
            begin
                prev_we    = 1'b1;
                prev_addr  = elm_reg[AW-1:0];
                prev_wdata = pos_reg;
                next_we    = 1'b1;
                next_addr  = elm_reg[AW-1:0];
                next_wdata = nx_reg;
            end
            S_LINK_WR2:
            begin
                next_we    = 1'b1;
                next_addr  = pos_reg[AW-1:0];
                next_wdata = elm_reg;
                prev_we    = 1'b1;
                prev_addr  = link_nx[AW-1:0];
                prev_wdata = elm_reg;
            end
            S_RD_HEAD:
            begin
                next_addr = AW'(tgt_reg);
            end
            S_RD_ELEM:
            begin
                prev_addr = elm_reg[AW-1:0];
                next_addr = elm_reg[AW-1:0];
            end
            S_UNLINK_WR1:
            begin
                next_we    = 1'b1;
                next_addr  = pos_reg[AW-1:0];
                next_wdata = nx_reg;
                prev_we    = 1'b1;
                prev_addr  = nx_reg[AW-1:0];
                prev_wdata = pos_reg;
            end
            S_UNLINK_WR2:
            begin
                prev_we   = 1'b1;
                prev_addr = elm_reg[AW-1:0];
                next_we   = 1'b1;
                next_addr = elm_reg[AW-1:0];
            end
            default:
            begin
                prev_we = 1'b0;
            end
        endcase
    end

    // Prev link memory, single port
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_addr] <= prev_wdata;
        end
        else
        begin
            prev_rd_reg <= prev_mem[prev_addr];
        end
    end

    // Next link memory, single port
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_addr] <= next_wdata;
        end
        else
        begin
            next_rd_reg <= next_mem[next_addr];
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            op_reg          <= dlq_pkg::OP_INIT;
            tgt_reg         <= '0;
            tpool_reg       <= 1'b0;
            elm_reg         <= '0;
            epool_reg       <= 1'b0;
            pos_reg         <= '0;
            pos_ok_reg      <= 1'b0;
            nx_reg          <= '0;
            res_node_reg    <= '0;
            res_valid_reg   <= 1'b0;
            res_empty_reg   <= 1'b0;
            result_node_reg <= '0;
            node_valid_reg  <= 1'b0;
            list_empty_reg  <= 1'b0;
        end
        else
        begin
            // Result beat taken; the finish step reloads the register itself
            if (out_valid_reg && !out_stall && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        op_reg        <= dlq_pkg::opcode_t'(opcode);
                        tgt_reg       <= target_node;
                        tpool_reg     <= in_tpool;
                        elm_reg       <= LW'(element_node);
                        epool_reg     <= in_epool;
                        pos_reg       <= LW'(target_node);
                        pos_ok_reg    <= in_tpool;
                        res_node_reg  <= '0;
                        res_valid_reg <= 1'b0;
                        res_empty_reg <= 1'b0;
                        case (dlq_pkg::opcode_t'(opcode))
                            dlq_pkg::OP_INIT:   state_reg <= S_INIT_WR;
                            dlq_pkg::OP_PUSH:   state_reg <= S_RD_TAIL;
                            dlq_pkg::OP_POP:    state_reg <= S_RD_HEAD;
                            dlq_pkg::OP_REMOVE: state_reg <= S_RD_ELEM;
                            dlq_pkg::OP_INSERT: state_reg <= S_RD_POS;
                            dlq_pkg::OP_EMPTY:  state_reg <= S_RD_HEAD;
                            default:            state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_INIT_WR:
                begin
                    state_reg <= S_FINISH;
                end
                S_RD_TAIL:
                begin
                    state_reg <= (tpool_reg && epool_reg) ? S_TAIL_DATA : S_FINISH;
                end
                S_TAIL_DATA:
                begin
                    // Tail node becomes the insert position
                    pos_reg    <= prev_rd_reg;
                    pos_ok_reg <= prev_rd_reg < LINK_NULL;
                    state_reg  <= S_RD_POS;
                end
                S_RD_POS:
                begin
                    state_reg <= (pos_ok_reg && epool_reg) ? S_POS_DATA : S_FINISH;
                end
                S_POS_DATA:
                begin
                    nx_reg    <= next_rd_reg;
                    state_reg <= (next_rd_reg < LINK_NULL) ? S_LINK_WR1 : S_FINISH;
                end
                S_LINK_WR1:
                begin
                    state_reg <= S_LINK_WR2;
                end
                S_LINK_WR2:
                begin
                    state_reg <= S_FINISH;
                end
                S_RD_HEAD:
                begin
                    state_reg <= tpool_reg ? S_HEAD_DATA : S_FINISH;
                end
                S_HEAD_DATA:
                begin
                    if (op_reg == dlq_pkg::OP_EMPTY)
                    begin
                        res_empty_reg <= head_is_root;
                        state_reg     <= S_FINISH;
                    end
                    else if (head_is_root || !(next_rd_reg < LINK_NULL))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        // Head node is the one to unlink
                        elm_reg   <= next_rd_reg;
                        epool_reg <= 1'b1;
                        state_reg <= S_RD_ELEM;
                    end
                end
                S_RD_ELEM:
                begin
                    state_reg <= epool_reg ? S_ELEM_DATA : S_FINISH;
                end
                S_ELEM_DATA:
                begin
                    pos_reg <= prev_rd_reg;
                    nx_reg  <= next_rd_reg;
                    // Unlinked node: leave everything alone
                    if ((prev_rd_reg < LINK_NULL) && (next_rd_reg < LINK_NULL))
                    begin
                        state_reg <= S_UNLINK_WR1;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_UNLINK_WR1:
                begin
                    state_reg <= S_UNLINK_WR2;
                end
                S_UNLINK_WR2:
                begin
                    if (op_reg == dlq_pkg::OP_POP)
                    begin
                        res_node_reg  <= elm_reg;
                        res_valid_reg <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // Load the output register once it is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        result_node_reg <= dlq_pkg::NODE_W'(res_node_reg);
                        node_valid_reg  <= res_valid_reg;
                        list_empty_reg  <= res_empty_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("item accepted while another is in work");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && node_valid) |-> !list_empty)
        else $error("pop result flagged as empty query");

    a_link_range: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_we || next_we) |-> (prev_wdata <= LINK_NULL && next_wdata <= LINK_NULL))
        else $error("link write beyond null code");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result beat raised outside finish step");

endmodule

`default_nettype wire

// ===== test/dlq_link_checker.sv =====
// Checker for the doubly linked queue manager: watches both channels, predicts
// each result beat from its own copy of the prev/next link tables and compares.
// Depends on dlq_pkg for field widths, pool size and opcodes.
`timescale 1ns / 100ps

module dlq_link_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic [dlq_pkg::OP_W-1:0]   opcode,
    input  wire logic [dlq_pkg::NODE_W-1:0] target_node,
    input  wire logic [dlq_pkg::NODE_W-1:0] element_node,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [dlq_pkg::NODE_W-1:0] result_node,
    input  wire logic                       node_valid,
    input  wire logic                       list_empty,
    output int                              mismatch_total,
    output int                              outstanding,
    output int                              results_seen,
    output int                              pops_returned,
    output int                              empty_answers
);

    localparam int LINK_W = $clog2(dlq_pkg::NODE_COUNT_DEF) + 1;
    typedef logic [LINK_W-1:0] link_t;
    localparam link_t LINK_NULL = link_t'(dlq_pkg::NODE_COUNT_DEF);

    typedef struct packed {
        logic [dlq_pkg::NODE_W-1:0] node;
        logic                       valid;
        logic                       empty;
    } list_answer_t;

    // shadow link tables and the answers still owed by the block
    link_t        prev_link [dlq_pkg::NODE_COUNT_DEF];
    link_t        next_link [dlq_pkg::NODE_COUNT_DEF];
    list_answer_t answers_q [$];
    int           fail_count;
    int           beat_count;
    int           pop_hits;
    int           empty_hits;

    function automatic bit is_node(link_t l);
        return l < link_t'(dlq_pkg::NODE_COUNT_DEF);
    endfunction

    // unlink e from its neighbors; refused when either of its links is null
    function automatic bit detach_node(link_t e);
        link_t p;
        link_t n;
        p = prev_link[e];
        n = next_link[e];
        if (!is_node(p) || !is_node(n))
            return 1'b0;
        next_link[p] = n;
        prev_link[n] = p;
        prev_link[e] = LINK_NULL;
        next_link[e] = LINK_NULL;
        return 1'b1;
    endfunction

    // link e after pos; writes go in a fixed order, the last one re-reads e.next
    function automatic void attach_after(link_t pos, link_t e);
        link_t nx;
        if (!is_node(pos))
            return;
        nx = next_link[pos];
        if (!is_node(nx))
            return;
        prev_link[e]   = pos;
        next_link[e]   = nx;
        next_link[pos] = e;
        nx = next_link[e];
        if (is_node(nx))
            prev_link[nx] = e;
    endfunction

    // apply one beat to the shadow tables and return the answer it gives
    function automatic list_answer_t apply_list_op(logic [dlq_pkg::OP_W-1:0] op,
                                                   link_t tgt, link_t elm);
        list_answer_t ans;
        link_t        head;
        ans = '0;
        case (op)
            dlq_pkg::OP_INIT:
            begin
                prev_link[tgt] = tgt;
                next_link[tgt] = tgt;
            end
            dlq_pkg::OP_PUSH:   attach_after(prev_link[tgt], elm);
            dlq_pkg::OP_POP:
            begin
                head = next_link[tgt];
                if (head != tgt && is_node(head) && detach_node(head))
                begin
                    ans.node  = head[dlq_pkg::NODE_W-1:0];
                    ans.valid = 1'b1;
                end
            end
            dlq_pkg::OP_REMOVE: void'(detach_node(elm));
            dlq_pkg::OP_INSERT: attach_after(tgt, elm);
            dlq_pkg::OP_EMPTY:  ans.empty = (next_link[tgt] == tgt);
            default: ;
        endcase
        return ans;
    endfunction

    // compare result beats first, then record the answer for an input beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        list_answer_t got;
        list_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < dlq_pkg::NODE_COUNT_DEF; i++)
            begin
                prev_link[i] = LINK_NULL;
                next_link[i] = LINK_NULL;
            end
            answers_q.delete();
            fail_count = 0;
            beat_count = 0;
            pop_hits   = 0;
            empty_hits = 0;
            mismatch_total <= 0;
            outstanding    <= 0;
            results_seen   <= 0;
            pops_returned  <= 0;
            empty_answers  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{node: result_node, valid: node_valid, empty: list_empty};
                beat_count++;
                if (answers_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result beat %0d arrived with nothing owed: ",
                                  "node %0d valid %0b empty %0b"},
                                 beat_count, got.node, got.valid, got.empty);
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (want.valid)
                        pop_hits++;
                    if (want.empty)
                        empty_hits++;
                    if (got.node !== want.node || got.valid !== want.valid ||
                        got.empty !== want.empty)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result beat %0d: want node %0d valid %0b ",
                                      "empty %0b, got node %0d valid %0b empty %0b"},
                                     beat_count, want.node, want.valid, want.empty,
                                     got.node, got.valid, got.empty);
                    end
                end
            end
            if (in_valid && !in_stall)
                answers_q.push_back(apply_list_op(opcode, link_t'(target_node),
                                                  link_t'(element_node)));
            mismatch_total <= fail_count;
            outstanding    <= answers_q.size();
            results_seen   <= beat_count;
            pops_returned  <= pop_hits;
            empty_answers  <= empty_hits;
        end
    end

endmodule

// ===== test/doubly_linked_queue_manager_test.sv =====
// Top of the doubly linked queue manager testbench: clock, reset, list
// command stimulus and result-side stalls. Depends on dlq_pkg, the block
// and dlq_link_checker, which predicts and compares.
`timescale 1ns / 100ps

module doubly_linked_queue_manager_test;

    localparam logic [dlq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [dlq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int ROOTS       = 4;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_GAP     = 14;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic [dlq_pkg::OP_W-1:0]   opcode       = '0;
    logic [dlq_pkg::NODE_W-1:0] target_node  = '0;
    logic [dlq_pkg::NODE_W-1:0] element_node = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b1;
    logic [dlq_pkg::NODE_W-1:0] result_node;
    logic                       node_valid;
    logic                       list_empty;

    int mismatch_total;
    int outstanding;
    int results_seen;
    int pops_returned;
    int empty_answers;

    // stimulus-side bookkeeping: roots of this phase, nodes believed linked
    logic [dlq_pkg::NODE_W-1:0] roots [ROOTS];
    logic [dlq_pkg::NODE_W-1:0] linked_q [$];
    bit                         tx_eager    = 1'b0;
    bit                         rx_eager    = 1'b0;
    bit                         hold_asked  = 1'b0;
    bit                         hold_done;
    int                         rx_countdown;

    always #10 clk = ~clk;

    doubly_linked_queue_manager dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .target_node  (target_node),
        .element_node (element_node),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_node  (result_node),
        .node_valid   (node_valid),
        .list_empty   (list_empty)
    );

    dlq_link_checker link_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .target_node    (target_node),
        .element_node   (element_node),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_node    (result_node),
        .node_valid     (node_valid),
        .list_empty     (list_empty),
        .mismatch_total (mismatch_total),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .pops_returned  (pops_returned),
        .empty_answers  (empty_answers)
    );

    function automatic int linked_slot(logic [dlq_pkg::NODE_W-1:0] n);
        foreach (linked_q[i])
            if (linked_q[i] == n)
                return i;
        return -1;
    endfunction

    // mostly a node that is neither a root nor linked; now and then any node
    function automatic logic [dlq_pkg::NODE_W-1:0] pick_free_node();
        logic [dlq_pkg::NODE_W-1:0] n;
        bit                         taken;
        n = 8'($urandom);
        if ($urandom_range(0, 19) == 0)
            return n;
        for (int tries = 0; tries < 64; tries++)
        begin
            n = 8'($urandom);
            taken = (linked_slot(n) >= 0);
            foreach (roots[i])
                if (roots[i] == n)
                    taken = 1'b1;
            if (!taken)
                return n;
        end
        return n;
    endfunction

    // result side: random hold-off per beat, one long hold when asked
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int w;
        int slot;
        if (!rst_n)
        begin
            out_stall    <= 1'b1;
            rx_countdown <= 1;
            hold_done    <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            if (node_valid)
            begin
                slot = linked_slot(result_node);
                if (slot >= 0)
                    linked_q.delete(slot);
            end
            if (hold_asked && !hold_done)
            begin
                w = LONG_HOLD;
                hold_done <= 1'b1;
            end
            else
                w = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
            out_stall    <= (w != 0);
            rx_countdown <= w;
        end
        else if (rx_countdown != 0)
        begin
            out_stall    <= (rx_countdown > 1);
            rx_countdown <= rx_countdown - 1;
        end
    end

    // offer one beat after a random gap and hold it until accepted
    task automatic send_item(logic [dlq_pkg::OP_W-1:0] op,
                             logic [dlq_pkg::NODE_W-1:0] tgt,
                             logic [dlq_pkg::NODE_W-1:0] elm);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        target_node  <= tgt;
        element_node <= elm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and let every owed result come back
    task automatic wait_for_results(int limit);
        int spins;
        spins = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            spins++;
        end
        while (outstanding != 0 && spins < limit);
    endtask

    // one random command, biased toward well-formed list traffic
    task automatic random_item();
        int                         dice;
        int                         slot;
        logic [dlq_pkg::NODE_W-1:0] root;
        logic [dlq_pkg::NODE_W-1:0] elm;
        dice = $urandom_range(0, 99);
        root = roots[$urandom_range(0, ROOTS - 1)];
        if (dice < 6)
            send_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
        else if (dice < 10)
            send_item(dlq_pkg::OP_INIT, root, 8'($urandom));
        else if (dice < 38)
        begin
            elm = pick_free_node();
            linked_q.push_back(elm);
            send_item(dlq_pkg::OP_PUSH, root, elm);
        end
        else if (dice < 56)
            send_item(dlq_pkg::OP_POP, root, 8'($urandom));
        else if (dice < 70)
        begin
            if (linked_q.size() != 0)
            begin
                slot = $urandom_range(0, linked_q.size() - 1);
                elm = linked_q[slot];
                linked_q.delete(slot);
            end
            else
                elm = 8'($urandom);
            send_item(dlq_pkg::OP_REMOVE, 8'($urandom), elm);
        end
        else if (dice < 86)
        begin
            elm = pick_free_node();
            if (linked_q.size() != 0 && $urandom_range(0, 1) == 1)
                root = linked_q[$urandom_range(0, linked_q.size() - 1)];
            linked_q.push_back(elm);
            send_item(dlq_pkg::OP_INSERT, root, elm);
        end
        else
            send_item(dlq_pkg::OP_EMPTY,
                      ($urandom_range(0, 7) == 0) ? 8'($urandom) : root,
                      8'($urandom));
    endtask

    initial
    begin : stimulus
        bit dup;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: untouched roots, edge nodes, unused opcodes
        send_item(dlq_pkg::OP_EMPTY, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_POP, 8'd255, 8'd255);
        send_item(dlq_pkg::OP_PUSH, 8'd7, 8'd8);
        send_item(dlq_pkg::OP_INSERT, 8'd9, 8'd10);
        send_item(dlq_pkg::OP_REMOVE, 8'd0, 8'd255);
        send_item(dlq_pkg::OP_INIT, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_EMPTY, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_POP, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_PUSH, 8'd0, 8'd255);
        send_item(dlq_pkg::OP_PUSH, 8'd0, 8'd1);
        send_item(dlq_pkg::OP_INSERT, 8'd255, 8'd128);
        send_item(dlq_pkg::OP_EMPTY, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_POP, 8'd0, 8'd0);
        send_item(dlq_pkg::OP_REMOVE, 8'd0, 8'd128);
        // second remove hits an unlinked node
        send_item(dlq_pkg::OP_REMOVE, 8'd0, 8'd128);
        // element already on the list
        send_item(dlq_pkg::OP_PUSH, 8'd0, 8'd1);
        send_item(dlq_pkg::OP_INSERT, 8'd0, 8'd0);
        send_item(OP_SPARE_LO, 8'd255, 8'd255);
        send_item(OP_SPARE_HI, 8'd0, 8'd0);
        // head of root 3 gets unlinked behind its back, then popped
        send_item(dlq_pkg::OP_INIT, 8'd3, 8'd0);
        send_item(dlq_pkg::OP_PUSH, 8'd3, 8'd4);
        send_item(dlq_pkg::OP_INIT, 8'd4, 8'd0);
        send_item(dlq_pkg::OP_REMOVE, 8'd3, 8'd4);
        send_item(dlq_pkg::OP_POP, 8'd3, 8'd0);
        send_item(dlq_pkg::OP_POP, 8'd0, 8'd0);
        wait_for_results(100000);

        // random phases, each on a fresh set of roots
        for (int phase = 0; phase < PHASES; phase++)
        begin
            tx_eager = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_eager <= (phase == 0) || ($urandom_range(0, 3) == 0);
            if (phase == 2)
                hold_asked <= 1'b1;
            for (int i = 0; i < ROOTS; i++)
            begin
                do
                begin
                    roots[i] = 8'($urandom);
                    dup = 1'b0;
                    for (int j = 0; j < i; j++)
                        if (roots[j] == roots[i])
                            dup = 1'b1;
                end
                while (dup);
            end
            linked_q.delete();
            foreach (roots[i])
                send_item(dlq_pkg::OP_INIT, roots[i], 8'($urandom));
            repeat (PHASE_ITEMS - ROOTS)
                random_item();
            wait_for_results(100000);
        end

        // trailing window catches any stray result beat
        repeat (20) @(posedge clk);
        $display("%0d result beats checked; %0d pops gave a node, %0d queries saw empty",
                 results_seen, pops_returned, empty_answers);
        $display("roots, tails and heads exercised over %0d phases with random gaps and stalls",
                 PHASES);
        if (mismatch_total == 0 && outstanding == 0)
            $display("doubly_linked_queue_manager: match");
        else
            $display("doubly_linked_queue_manager: mismatch");
        $finish;
    end

    // watchdog far above the slowest legal run
    initial
    begin
        #15_000_000;
        $display("doubly_linked_queue_manager: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/dlq_pkg.sv
design/doubly_linked_queue_manager.sv
test/dlq_link_checker.sv
test/doubly_linked_queue_manager_test.sv
